@@ hw/rtl/ttdf_pkg.sv @@
// package for the test tone dac formatter: widths, constants and code types
`timescale 1ns / 1ps

package ttdf_pkg;

  // phase accumulator default width
  localparam int unsigned PHASE_BITS_DEF = 24;

  // field widths
  localparam int unsigned STEP_W    = 24;
  localparam int unsigned PF_W      = 24;
  localparam int unsigned AMP_W     = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // folded phase landmarks
  localparam logic [PF_W-1:0] PF_HALF    = 24'h800000;
  localparam logic [PF_W-1:0] PF_QUARTER = 24'h400000;

  // q22 magnitudes and the serial multiplier
  localparam int unsigned Q         = 22;
  localparam int unsigned MAG_W     = 23;
  localparam int unsigned MUL_AW    = MAG_W;
  localparam int unsigned MUL_BW    = 24;
  localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;
  localparam int unsigned A3_W      = MUL_AW + 2;
  localparam int unsigned MUL_STEPS = MUL_BW / 2;
  localparam int unsigned CNT_W     = 4;
  localparam logic [20:0] THIRD_Q22 = 21'd1397962;

  // gain divider: floor(amp^2 * 4096 / 625)
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned AMP_SQ_W  = 14;
  localparam int unsigned GAIN_SH   = 12;
  localparam int unsigned DIV_N_W   = AMP_SQ_W + GAIN_SH;
  localparam int unsigned DIV_R_W   = 10;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_R_W-1:0] GAIN_DEN = 10'd625;
  localparam logic [AMP_W-1:0]   AMP_CAP  = 8'd100;
  localparam logic [GAIN_W-1:0]  GAIN_ONE = 17'h10000;

  // output scaling
  localparam int unsigned FS_W     = 23;
  localparam int unsigned SCALE_SH = 38;
  localparam int unsigned SPLIT    = SCALE_SH - FS_W;
  localparam int unsigned SAMP_W   = 24;
  localparam int unsigned PAD_W    = WORD_W - SAMP_W;
  localparam logic [FS_W-1:0] FULL_SCALE = 23'h7fffff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP,
    CFG_AMP_LEVEL,
    CFG_SIXTEEN_BIT,
    CFG_TOGGLE_MODE,
    CFG_LEFT_LOW,
    CFG_LEFT_HIGH,
    CFG_RIGHT_LOW,
    CFG_RIGHT_HIGH
  } cfg_idx_e;

  // multiplier passes
  typedef enum logic [1:0] {
    OP_SQUARE,
    OP_CUBE,
    OP_THIRD,
    OP_GAIN
  } mul_op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_LOAD,
    ST_TRIPLE,
    ST_RUN,
    ST_TERM,
    ST_CMAG,
    ST_SCALE,
    ST_EMIT
  } state_e;

endpackage

@@ hw/rtl/ttdf_tick_if.sv @@
// channel interface carrying tick items
`timescale 1ns / 1ps

interface ttdf_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

@@ hw/rtl/ttdf_frame_if.sv @@
// channel interface carrying stereo dac word items
`timescale 1ns / 1ps

interface ttdf_frame_if
  import ttdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] left_word;
  logic [WORD_W-1:0] right_word;

  modport source (output valid, output left_word, output right_word, input ready);
  modport sink (input valid, input left_word, input right_word, output ready);
endinterface

@@ hw/rtl/test_tone_dac_formatter.sv @@
// test tone generator: phase accumulator, cubic cosine, gain, dac word formatting
//
// Usage: write the eight configuration registers through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle. Each item on tick_i with tick = 1 advances
// the phase by phase_step and produces one item on frame_o holding the left and
// right dac words; an item with tick = 0 is taken and produces nothing.
// The result item becomes valid in the same cycle that tick_i is ready again; no new tick
// is taken while an item is in work. Most of the work falls to the shared multiplier, which
// retires two multiplier bits per cycle and makes four 12-digit passes (x^2, x^3, x^3/3
// and the gain product), each with operand set-up in the LOAD and TRIPLE states. The gain
// divider runs in parallel, and the gain pass waits for it if it is still busy.
// Reset clears the phase, all configuration registers and the output valid flag.
// When the receiver stalls the finished item waits in the output register; the
// next tick is taken meanwhile, and its result waits in the last stage until
// the output register frees up.
`timescale 1ns / 1ps

module test_tone_dac_formatter
  import ttdf_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  ttdf_tick_if.sink            tick_i,
  ttdf_frame_if.source         frame_o
);

  // configuration registers
  logic [STEP_W-1:0] step_q;
  logic [AMP_W-1:0]  amp_q;
  logic              sixteen_q;
  logic              toggle_q;
  logic [WORD_W-1:0] left_lo_q;
  logic [WORD_W-1:0] left_hi_q;
  logic [WORD_W-1:0] right_lo_q;
  logic [WORD_W-1:0] right_hi_q;

  // sequencer
  state_e  state_q;
  state_e  state_d;
  mul_op_e op_q;
  logic    in_ready;
  logic    tick_go;
  logic    mul_load;
  logic    run_last;
  logic    out_load;
  logic    out_free;

  // phase
  logic [PHASE_BITS-1:0] acc_q;
  logic [PHASE_BITS-1:0] inc;
  logic [PF_W-1:0]       pf;
  logic [PF_W-1:0]       pff_q;

  // operands and intermediates
  logic             xneg_new;
  logic [MAG_W-1:0] m_new;
  logic [MAG_W-1:0] m_q;
  logic             xneg_q;
  logic [MAG_W-1:0] em_q;
  logic [MAG_W-1:0] cmag_q;
  logic [MAG_W+1:0] cmag_sum;
  logic             p_round;

  // serial multiplier
  logic [MUL_AW-1:0] a_sel;
  logic [MUL_BW-1:0] b_sel;
  logic [MUL_AW-1:0] a_q;
  logic [A3_W-1:0]   a3_q;
  logic [MUL_PW-1:0] p_q;
  logic [A3_W-1:0]   addend;
  logic [A3_W-1:0]   psum;
  logic [CNT_W-1:0]  cnt_q;

  // gain divider
  logic [2*AMP_W-1:0]   amp_sq;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_R_W-1:0]   dr_q;
  logic [DIV_N_W-1:0]   dq_q;
  logic [DIV_R_W:0]     trial;
  logic [DIV_R_W:0]     trial_diff;
  logic                 trial_ge;
  logic                 div_busy;
  logic [GAIN_W-1:0]    gain;

  // scaling and output
  logic              ovf;
  logic              below;
  logic [FS_W-1:0]   sm_q;
  logic              pos_q;
  logic [SAMP_W-1:0] samp;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] left_w;
  logic [WORD_W-1:0] right_w;
  logic              out_valid_q;
  logic [WORD_W-1:0] left_q;
  logic [WORD_W-1:0] right_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      amp_q      <= '0;
      sixteen_q  <= 1'b0;
      toggle_q   <= 1'b0;
      left_lo_q  <= '0;
      left_hi_q  <= '0;
      right_lo_q <= '0;
      right_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_STEP:  step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_AMP_LEVEL:   amp_q      <= cfg_data_i[AMP_W-1:0];
        CFG_SIXTEEN_BIT: sixteen_q  <= cfg_data_i[0];
        CFG_TOGGLE_MODE: toggle_q   <= cfg_data_i[0];
        CFG_LEFT_LOW:    left_lo_q  <= cfg_data_i;
        CFG_LEFT_HIGH:   left_hi_q  <= cfg_data_i;
        CFG_RIGHT_LOW:   right_lo_q <= cfg_data_i;
        CFG_RIGHT_HIGH:  right_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step rescaling and 24-bit view of the phase
  generate
    if (PHASE_BITS >= STEP_W) begin : g_phase_wide
      assign inc = PHASE_BITS'(step_q) << (PHASE_BITS - STEP_W);
      assign pf  = acc_q[PHASE_BITS-1 -: PF_W];
    end else begin : g_phase_narrow
      assign inc = step_q[STEP_W-1 -: PHASE_BITS];
      assign pf  = PF_W'(acc_q) << (PF_W - PHASE_BITS);
    end
  endgenerate

  assign tick_go = tick_i.valid && in_ready && tick_i.tick;
  assign out_free = !out_valid_q || frame_o.ready;
  assign div_busy = (div_cnt_q != '0);
  assign run_last = (state_q == ST_RUN) && (cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (tick_go) state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_LOAD;
      ST_LOAD:   if (mul_load) state_d = ST_TRIPLE;
      ST_TRIPLE: state_d = ST_RUN;
      ST_RUN: begin
        if (cnt_q == '0) begin
          unique case (op_q)
            OP_SQUARE: state_d = ST_LOAD;
            OP_CUBE:   state_d = ST_LOAD;
            OP_THIRD:  state_d = ST_TERM;
            OP_GAIN:   state_d = ST_SCALE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_TERM:   state_d = ST_CMAG;
      ST_CMAG:   state_d = ST_LOAD;
      ST_SCALE:  state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    mul_load = (state_q == ST_LOAD) && !((op_q == OP_GAIN) && div_busy);
    out_load = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SQUARE;
    end else begin
      state_q <= state_d;
      if (tick_go) begin
        op_q <= OP_SQUARE;
      end else if (run_last) begin
        unique case (op_q)
          OP_SQUARE: op_q <= OP_CUBE;
          OP_CUBE:   op_q <= OP_THIRD;
          OP_THIRD:  op_q <= OP_GAIN;
          OP_GAIN:   op_q <= OP_GAIN;
          default:   op_q <= OP_SQUARE;
        endcase
      end
    end
  end

  // phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (tick_go) begin
      acc_q <= acc_q + inc;
    end
  end

  // |x| and sign of x = folded phase minus one quarter
  assign xneg_new = (pff_q < PF_QUARTER);
  assign m_new    = xneg_new ? MAG_W'(PF_QUARTER - pff_q) : MAG_W'(pff_q - PF_QUARTER);

  // rounding bit for negative products: floor of a negative value rounds its magnitude up
  assign p_round = xneg_q && (|p_q[Q-1:0]);

  // operand selection per pass
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (op_q)
      OP_SQUARE: begin
        a_sel = m_new;
        b_sel = MUL_BW'(m_new);
      end
      OP_CUBE: begin
        a_sel = m_q;
        b_sel = MUL_BW'(p_q[Q+MAG_W-1:Q]);
      end
      OP_THIRD: begin
        a_sel = p_q[Q+MAG_W-1:Q] + MAG_W'(p_round);
        b_sel = MUL_BW'(THIRD_Q22);
      end
      OP_GAIN: begin
        a_sel = cmag_q;
        b_sel = MUL_BW'(gain);
      end
      default: ;
    endcase
  end

  // radix-4 digit of the multiplier selects 0, a, 2a or 3a
  always_comb begin
    unique case (p_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = A3_W'(a_q);
      2'd2:    addend = A3_W'({a_q, 1'b0});
      default: addend = a3_q;
    endcase
  end
  assign psum = A3_W'(p_q[MUL_PW-1:MUL_BW]) + addend;

  // |c| = floor or ceil of 3 * |x - t| / 2
  assign cmag_sum = (MAG_W+2)'(em_q) + (MAG_W+2)'({em_q, 1'b0}) + (MAG_W+2)'(!xneg_q);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FOLD) begin
      pff_q <= (pf > PF_HALF) ? (~pf + PF_W'(1)) : pf;
    end
    if (mul_load) begin
      a_q <= a_sel;
      p_q <= {{MUL_AW{1'b0}}, b_sel};
      if (op_q == OP_SQUARE) begin
        m_q    <= m_new;
        xneg_q <= xneg_new;
      end
    end
    if (state_q == ST_TRIPLE) begin
      a3_q  <= A3_W'(a_q) + A3_W'({a_q, 1'b0});
      cnt_q <= CNT_W'(MUL_STEPS - 1);
    end
    if (state_q == ST_RUN) begin
      p_q   <= {psum, p_q[MUL_BW-1:2]};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (state_q == ST_TERM) begin
      em_q <= m_q - p_q[Q+MAG_W-1:Q] - MAG_W'(p_round);
    end
    if (state_q == ST_CMAG) begin
      cmag_q <= cmag_sum[MAG_W:1];
    end
    if (state_q == ST_SCALE) begin
      sm_q  <= ovf ? FULL_SCALE : (p_q[SCALE_SH-1:SPLIT] - FS_W'(below));
      pos_q <= xneg_q && (|p_q);
    end
  end

  // gain divider, one quotient bit per cycle
  assign amp_sq     = (2*AMP_W)'(amp_q) * (2*AMP_W)'(amp_q);
  assign trial      = {dr_q, dq_q[DIV_N_W-1]};
  assign trial_diff = trial - (DIV_R_W+1)'(GAIN_DEN);
  assign trial_ge   = (trial >= (DIV_R_W+1)'(GAIN_DEN));
  assign gain       = (amp_q >= AMP_CAP) ? GAIN_ONE : GAIN_W'(dq_q[HALF_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (tick_go) begin
      div_cnt_q <= DIV_CNT_W'(DIV_N_W);
    end else if (div_busy) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      dr_q <= '0;
      dq_q <= {amp_sq[AMP_SQ_W-1:0], {GAIN_SH{1'b0}}};
    end else if (div_busy) begin
      dr_q <= trial_ge ? trial_diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
      dq_q <= {dq_q[DIV_N_W-2:0], trial_ge};
    end
  end

  // sample magnitude = trunc(p * (2^23 - 1) / 2^38), clamped
  assign ovf   = |p_q[MUL_PW-1:SCALE_SH];
  assign below = ({p_q[SPLIT-1:0], {FS_W{1'b0}}} < p_q[SCALE_SH-1:0]);

  // word formatting
  always_comb begin
    samp    = xneg_q ? {1'b0, sm_q} : (SAMP_W'(0) - {1'b0, sm_q});
    word    = {samp, {PAD_W{1'b0}}};
    left_w  = toggle_q ? (pos_q ? left_hi_q : left_lo_q) : word;
    right_w = toggle_q ? (pos_q ? right_hi_q : right_lo_q) : word;
    if (sixteen_q) begin
      left_w  = {{HALF_W{1'b0}}, left_w[WORD_W-1:HALF_W]};
      right_w = {{HALF_W{1'b0}}, right_w[WORD_W-1:HALF_W]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (frame_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q  <= left_w;
      right_q <= right_w;
    end
  end

  // channel ports
  assign tick_i.ready       = in_ready;
  assign frame_o.valid      = out_valid_q;
  assign frame_o.left_word  = left_q;
  assign frame_o.right_word = right_q;

endmodule

@@ sim/test_tone_dac_formatter_tb.sv @@
// testbench for the test tone dac formatter: tick stimulus, register settings, frame checking
`timescale 1ns / 1ps

module test_tone_dac_formatter_tb
  import ttdf_pkg::*;
;

  localparam longint Q22_THIRD     = 1397962;
  localparam longint SAMPLE_MAX    = 8388607;
  localparam longint Q22_QUARTER   = 4194304;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     STALL_LIMIT   = 2000;
  localparam int     RANDOM_BLOCKS = 9;
  localparam int     BLOCK_ITEMS   = 76;

  typedef struct packed {
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;
  } dac_frame_t;

  // mirror of the tone path plus the queue of frames still owed by the block
  class frame_scoreboard;
    logic [STEP_W-1:0] step_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic              sixteen_reg;
    logic              toggle_reg;
    logic [WORD_W-1:0] test_words [4];
    logic [PF_W-1:0]   phase;
    dac_frame_t        frames_due [$];
    int unsigned       mismatches;

    function new();
      step_reg    = '0;
      amp_reg     = '0;
      sixteen_reg = 1'b0;
      toggle_reg  = 1'b0;
      foreach (test_words[i]) test_words[i] = '0;
      phase       = '0;
      mismatches  = 0;
    endfunction

    // register write, bits above the register width dropped
    function void set_reg(cfg_idx_e idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_PHASE_STEP:  step_reg = data[STEP_W-1:0];
        CFG_AMP_LEVEL:   amp_reg = data[AMP_W-1:0];
        CFG_SIXTEEN_BIT: sixteen_reg = data[0];
        CFG_TOGGLE_MODE: toggle_reg = data[0];
        CFG_LEFT_LOW:    test_words[0] = data;
        CFG_LEFT_HIGH:   test_words[1] = data;
        CFG_RIGHT_LOW:   test_words[2] = data;
        CFG_RIGHT_HIGH:  test_words[3] = data;
        default: ;
      endcase
    endfunction

    // advance the phase and form the stereo dac words for it
    function dac_frame_t next_tone_frame();
      logic [PF_W-1:0]   pf;
      longint            x, x2, x3, t, c, g, prod, scaled, samp;
      logic [WORD_W-1:0] lw, rw;
      dac_frame_t        fr;
      phase = phase + step_reg;
      pf = phase;
      if (pf > PF_HALF) pf = '0 - pf;
      x  = longint'({40'd0, pf}) - Q22_QUARTER;
      x2 = (x * x) >>> 22;
      x3 = (x2 * x) >>> 22;
      t  = (x3 * Q22_THIRD) >>> 22;
      c  = (-3 * (x - t)) >>> 1;
      if (amp_reg >= 8'd100) g = 65536;
      else g = (longint'({56'd0, amp_reg}) * longint'({56'd0, amp_reg}) * 65536) / 10000;
      prod   = c * g;
      scaled = prod * SAMPLE_MAX;
      // scale truncates toward zero
      if (scaled >= 0) samp = scaled >>> 38;
      else samp = -((-scaled) >>> 38);
      if (samp > SAMPLE_MAX) samp = SAMPLE_MAX;
      else if (samp < -SAMPLE_MAX) samp = -SAMPLE_MAX;
      if (toggle_reg) begin
        lw = (prod > 0) ? test_words[1] : test_words[0];
        rw = (prod > 0) ? test_words[3] : test_words[2];
      end else begin
        lw = 32'(samp << 8);
        rw = lw;
      end
      if (sixteen_reg) begin
        lw = lw >> 16;
        rw = rw >> 16;
      end
      fr.left_word  = lw;
      fr.right_word = rw;
      return fr;
    endfunction

    // accepted tick item; an idle tick owes nothing
    function void note_tick(logic t);
      if (t) frames_due.push_back(next_tone_frame());
    endfunction

    function void check_frame(logic [WORD_W-1:0] lw, logic [WORD_W-1:0] rw);
      dac_frame_t exp_fr;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame left %h right %h", $time, lw, rw);
        mismatches++;
        return;
      end
      exp_fr = frames_due.pop_front();
      if (lw !== exp_fr.left_word) begin
        $display("%0t: left_word expected %h actual %h", $time, exp_fr.left_word, lw);
        mismatches++;
      end
      if (rw !== exp_fr.right_word) begin
        $display("%0t: right_word expected %h actual %h", $time, exp_fr.right_word, rw);
        mismatches++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0] cfg_data;

  int send_idle_pct = 15;
  int recv_idle_pct = 46;
  int idle_cycles   = 0;

  frame_scoreboard sb = new();

  ttdf_tick_if  tick_bus ();
  ttdf_frame_if frame_bus ();

  test_tone_dac_formatter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_bus),
    .frame_o    (frame_bus)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    frame_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // frame checking
  always @(posedge clk_i) begin
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      sb.check_frame(frame_bus.left_word, frame_bus.right_word);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((tick_bus.valid && tick_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("test_tone_dac_formatter test failed");
      $finish;
    end
  end

  // one register write; the enable is lowered by the caller
  task automatic write_reg(input cfg_idx_e idx, input logic [WORD_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // full register set, entered at a falling edge with the block idle
  task automatic apply_setting(input logic [WORD_W-1:0] step_d, input logic [WORD_W-1:0] amp_d,
                               input logic [WORD_W-1:0] six_d, input logic [WORD_W-1:0] tog_d,
                               input logic [WORD_W-1:0] ll_d, input logic [WORD_W-1:0] lh_d,
                               input logic [WORD_W-1:0] rl_d, input logic [WORD_W-1:0] rh_d);
    write_reg(CFG_PHASE_STEP, step_d);
    write_reg(CFG_AMP_LEVEL, amp_d);
    write_reg(CFG_SIXTEEN_BIT, six_d);
    write_reg(CFG_TOGGLE_MODE, tog_d);
    write_reg(CFG_LEFT_LOW, ll_d);
    write_reg(CFG_LEFT_HIGH, lh_d);
    write_reg(CFG_RIGHT_LOW, rl_d);
    write_reg(CFG_RIGHT_HIGH, rh_d);
    cfg_we <= 1'b0;
  endtask

  // send one tick item, with an optional gap in front
  task automatic push_tick(input logic t);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(5, 70);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.tick  <= t;
    do @(posedge clk_i); while (!(tick_bus.valid && tick_bus.ready));
    sb.note_tick(t);
  endtask

  task automatic park_sender();
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
  endtask

  // wait out every owed frame, then any idle tick still in flight
  task automatic drain();
    park_sender();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] step_d, amp_d, six_d, tog_d;
    int                blk, n;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    tick_bus.valid  = 1'b0;
    tick_bus.tick   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero step at phase zero: positive clamp; junk above each register width
    apply_setting(32'hab000000, 32'h123456ff, 32'hfffffffe, 32'h00000002,
                  32'h00000000, 32'hffffffff, 32'ha5a5a5a5, 32'h5a5a5a5a);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    drain();

    // half-cycle step lands on the fold point: negative clamp, sixteen-bit words
    apply_setting(32'h00800000, 32'd100, 32'd1, 32'd0,
                  32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    drain();

    // quarter steps in toggle mode walk through zero, negative and positive samples
    apply_setting(32'hff400000, 32'd99, 32'd0, 32'd1,
                  32'h11111111, 32'h22222222, 32'h33333333, 32'h44444444);
    repeat (4) push_tick(1'b1);
    drain();

    // step just below the fold point with zero gain: toggle always picks the low words
    apply_setting(32'h007fffff, 32'hffffff00, 32'd1, 32'hffffffff,
                  32'hffffffff, 32'h00000000, 32'h80000001, 32'h7ffffffe);
    repeat (3) push_tick(1'b1);
    drain();

    // smallest nonzero step and gain
    apply_setting(32'h00000001, 32'd1, 32'd0, 32'd0,
                  32'h0, 32'h0, 32'h0, 32'h0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    drain();

    // random settings, idling pattern changes every third block
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk / 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      step_d = $urandom;
      case ($urandom_range(3))
        0: step_d[STEP_W-1:0] = STEP_W'($urandom_range(0, 4096));
        1: step_d[STEP_W-1:0] = STEP_W'(24'hffffff - $urandom_range(0, 4096));
        2: step_d[STEP_W-1:0] = $urandom_range(1) ? 24'h800000 : 24'h7fffff;
        default: ;
      endcase
      amp_d = $urandom;
      amp_d[AMP_W-1:0] = AMP_W'($urandom_range(1) ? $urandom_range(0, 99)
                                                   : $urandom_range(100, 255));
      six_d = $urandom;
      tog_d = $urandom;
      apply_setting(step_d, amp_d, six_d, tog_d, $urandom, $urandom, $urandom, $urandom);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        push_tick($urandom_range(99) < 85);
        // now and then hold off until the block has caught up
        if ($urandom_range(39) == 0) begin
          park_sender();
          while (sb.pending() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected frames never arrived", $time, sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("test_tone_dac_formatter test passed");
    end else begin
      $display("test_tone_dac_formatter test failed");
    end
    $finish;
  end

endmodule
